// ===== design/tcs_pkg.sv =====
package tcs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_word_t;

  typedef struct packed {
    logic        summary_valid;
    logic        accepted;
    logic [7:0]  content_type;
    logic [7:0]  major_version;
    logic [7:0]  minor_version;
    logic [15:0] record_length;
    logic        client_hello;
    logic [15:0] max_version;
    logic [7:0]  sni_length;
    logic        sni_byte_valid;
    logic [7:0]  sni_byte;
    logic [7:0]  sni_position;
  } out_word_t;

  localparam logic [7:0]  REC_HANDSHAKE   = 8'd22;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
  localparam logic [15:0] EXT_SNI         = 16'h0000;
  localparam logic [15:0] EXT_SUP_VERS    = 16'h002B;
  localparam logic [7:0]  HOST_NAME_TYPE  = 8'h00;
  localparam logic [23:0] FIXED_PART      = 24'd34;
  localparam logic [16:0] COUNT_MAX       = 17'h1FFFF;

  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_SNI   = 2'd1;
  localparam logic [1:0] CLS_SV    = 2'd2;

  typedef enum logic [17:0] {
    PH_HDR      = 18'b000000000000000001,
    PH_HS_TYPE  = 18'b000000000000000010,
    PH_HS_LEN   = 18'b000000000000000100,
    PH_FIXED    = 18'b000000000000001000,
    PH_SID_LEN  = 18'b000000000000010000,
    PH_SID      = 18'b000000000000100000,
    PH_CS_LEN   = 18'b000000000001000000,
    PH_CS       = 18'b000000000010000000,
    PH_COMP_LEN = 18'b000000000100000000,
    PH_COMP     = 18'b000000001000000000,
    PH_EXTS_LEN = 18'b000000010000000000,
    PH_EXT_TYPE = 18'b000000100000000000,
    PH_EXT_LEN  = 18'b000001000000000000,
    PH_SNI_HEAD = 18'b000010000000000000,
    PH_SNI_NAME = 18'b000100000000000000,
    PH_SV       = 18'b001000000000000000,
    PH_EXT_SKIP = 18'b010000000000000000,
    PH_IDLE     = 18'b100000000000000000
  } phase_t;

endpackage

// ===== design/tcs_fifo.sv =====
module tcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // store incoming word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end
endmodule

// ===== design/tcs_parser.sv =====
module tcs_parser #(
  parameter int SNI_CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  tcs_pkg::in_word_t   in_word,
  output tcs_pkg::out_word_t  out_word
);
  logic [7:0] b;
  logic       eop;
  assign b   = in_word.data_byte;
  assign eop = in_word.end_of_packet;

  tcs_pkg::phase_t phase, phase_next;
  logic [16:0] byte_count, byte_count_next;
  logic [23:0] field_rem, field_rem_next;
  logic [23:0] body_rem, body_rem_next;
  logic [15:0] exts_rem, exts_rem_next;
  logic [15:0] ext_rem, ext_rem_next;
  logic [23:0] shift, shift_next;
  logic [39:0] hdr, hdr_next;
  logic [15:0] best, best_next;
  logic [7:0]  host_len, host_len_next;
  logic        hello, hello_next;

  logic [23:0] body_dec, field_dec;
  logic [15:0] exts_dec, ext_dec;
  logic [23:0] sh16;
  logic [15:0] ext_n;
  logic [15:0] v;
  logic [16:0] cnt_inc;
  logic [17:0] rec_end;
  logic        acc;

  assign body_dec = (body_rem != '0) ? body_rem - 1'b1 : body_rem;
  assign field_dec = (field_rem != '0) ? field_rem - 1'b1 : field_rem;
  assign exts_dec = (exts_rem != '0) ? exts_rem - 1'b1 : exts_rem;
  assign ext_dec  = (ext_rem != '0) ? ext_rem - 1'b1 : ext_rem;
  assign sh16     = {8'h00, shift[7:0], b};
  assign ext_n    = {shift[7:0], b};

  // next parse state for one byte
  always_comb begin
    phase_next     = phase;
    field_rem_next = field_rem;
    body_rem_next  = body_rem;
    exts_rem_next  = exts_rem;
    ext_rem_next   = ext_rem;
    shift_next     = shift;
    hdr_next       = hdr;
    best_next      = best;
    host_len_next  = host_len;
    hello_next     = hello;
    v              = '0;
    out_word       = '0;
    case (phase)
      tcs_pkg::PH_HDR: begin
        hdr_next = {hdr[31:0], b};
        if (byte_count == 17'd4) begin
          if (hdr_next[39:32] == tcs_pkg::REC_HANDSHAKE && hdr_next[15:0] >= 16'd4) begin
            phase_next = tcs_pkg::PH_HS_TYPE;
          end else begin
            phase_next = tcs_pkg::PH_IDLE;
          end
        end
      end
      tcs_pkg::PH_HS_TYPE: begin
        if (b == tcs_pkg::HS_CLIENT_HELLO) begin
          phase_next     = tcs_pkg::PH_HS_LEN;
          field_rem_next = 24'd3;
          shift_next     = '0;
        end else begin
          phase_next = tcs_pkg::PH_IDLE;
        end
      end
      tcs_pkg::PH_HS_LEN: begin
        shift_next     = {shift[15:0], b};
        field_rem_next = field_dec;
        if (field_dec == '0) begin
          if ({1'b0, shift_next} + 25'd4 > {9'd0, hdr[15:0]}) begin
            phase_next = tcs_pkg::PH_IDLE;
          end else begin
            hello_next    = 1'b1;
            body_rem_next = shift_next;
            if (shift_next < tcs_pkg::FIXED_PART) begin
              phase_next = tcs_pkg::PH_IDLE;
            end else begin
              phase_next     = tcs_pkg::PH_FIXED;
              field_rem_next = tcs_pkg::FIXED_PART;
            end
          end
        end
      end
      tcs_pkg::PH_FIXED: begin
        body_rem_next  = body_dec;
        field_rem_next = field_dec;
        if (field_dec == '0) begin
          phase_next = (body_dec == '0) ? tcs_pkg::PH_IDLE : tcs_pkg::PH_SID_LEN;
        end
      end
      tcs_pkg::PH_SID_LEN, tcs_pkg::PH_COMP_LEN: begin
        body_rem_next = body_dec;
        if ({16'd0, b} > body_dec) begin
          phase_next = tcs_pkg::PH_IDLE;
        end else if (b == 8'd0) begin
          if (phase == tcs_pkg::PH_SID_LEN) begin
            if (body_dec < 24'd2) begin
              phase_next = tcs_pkg::PH_IDLE;
            end else begin
              phase_next = tcs_pkg::PH_CS_LEN;
              field_rem_next = 24'd2;
              shift_next = '0;
            end
          end else begin
            if (body_dec < 24'd2) begin
              phase_next = tcs_pkg::PH_IDLE;
            end else begin
              phase_next = tcs_pkg::PH_EXTS_LEN;
              field_rem_next = 24'd2;
              shift_next = '0;
            end
          end
        end else begin
          phase_next = (phase == tcs_pkg::PH_SID_LEN) ? tcs_pkg::PH_SID : tcs_pkg::PH_COMP;
          field_rem_next = {16'd0, b};
        end
      end
      tcs_pkg::PH_SID, tcs_pkg::PH_CS, tcs_pkg::PH_COMP: begin
        body_rem_next  = body_dec;
        field_rem_next = field_dec;
        if (field_dec == '0) begin
          if (phase == tcs_pkg::PH_CS) begin
            phase_next = (body_dec == '0) ? tcs_pkg::PH_IDLE : tcs_pkg::PH_COMP_LEN;
          end else if (body_dec < 24'd2) begin
            phase_next = tcs_pkg::PH_IDLE;
          end else begin
            phase_next = (phase == tcs_pkg::PH_SID) ? tcs_pkg::PH_CS_LEN
                                                   : tcs_pkg::PH_EXTS_LEN;
            field_rem_next = 24'd2;
            shift_next = '0;
          end
        end
      end
      tcs_pkg::PH_CS_LEN, tcs_pkg::PH_EXTS_LEN: begin
        body_rem_next  = body_dec;
        shift_next     = sh16;
        field_rem_next = field_dec;
        if (field_dec == '0) begin
          if (sh16 > body_dec) begin
            phase_next = tcs_pkg::PH_IDLE;
          end else if (phase == tcs_pkg::PH_EXTS_LEN) begin
            exts_rem_next = sh16[15:0];
            if (sh16[15:0] < 16'd4) begin
              phase_next = tcs_pkg::PH_IDLE;
            end else begin
              phase_next = tcs_pkg::PH_EXT_TYPE;
              field_rem_next = 24'd2;
              shift_next = '0;
            end
          end else if (sh16 == '0) begin
            phase_next = (body_dec == '0) ? tcs_pkg::PH_IDLE : tcs_pkg::PH_COMP_LEN;
          end else begin
            phase_next = tcs_pkg::PH_CS;
            field_rem_next = sh16;
          end
        end
      end
      tcs_pkg::PH_EXT_TYPE: begin
        body_rem_next  = body_dec;
        exts_rem_next  = exts_dec;
        shift_next     = sh16;
        field_rem_next = field_dec;
        if (field_dec == '0) begin
          if (sh16[15:0] == tcs_pkg::EXT_SNI) begin
            shift_next = {6'd0, tcs_pkg::CLS_SNI, 16'd0};
          end else if (sh16[15:0] == tcs_pkg::EXT_SUP_VERS) begin
            shift_next = {6'd0, tcs_pkg::CLS_SV, 16'd0};
          end else begin
            shift_next = {6'd0, tcs_pkg::CLS_OTHER, 16'd0};
          end
          phase_next     = tcs_pkg::PH_EXT_LEN;
          field_rem_next = 24'd2;
        end
      end
      tcs_pkg::PH_EXT_LEN: begin
        body_rem_next  = body_dec;
        exts_rem_next  = exts_dec;
        shift_next     = {shift[23:16], ext_n};
        field_rem_next = field_dec;
        if (field_dec == '0) begin
          if (ext_n > exts_dec) begin
            phase_next = tcs_pkg::PH_IDLE;
          end else begin
            ext_rem_next   = ext_n;
            field_rem_next = '0;
            shift_next     = '0;
            if (ext_n == '0) begin
              if (exts_dec < 16'd4) begin
                phase_next = tcs_pkg::PH_IDLE;
              end else begin
                phase_next = tcs_pkg::PH_EXT_TYPE;
                field_rem_next = 24'd2;
              end
            end else if (shift[17:16] == tcs_pkg::CLS_SNI && ext_n >= 16'd5) begin
              phase_next = tcs_pkg::PH_SNI_HEAD;
            end else if (shift[17:16] == tcs_pkg::CLS_SV && ext_n >= 16'd2) begin
              phase_next = tcs_pkg::PH_SV;
            end else begin
              phase_next = tcs_pkg::PH_EXT_SKIP;
            end
          end
        end
      end
      tcs_pkg::PH_SNI_HEAD, tcs_pkg::PH_SNI_NAME, tcs_pkg::PH_SV,
      tcs_pkg::PH_EXT_SKIP: begin
        body_rem_next = body_dec;
        exts_rem_next = exts_dec;
        ext_rem_next  = ext_dec;
        if (phase == tcs_pkg::PH_SNI_HEAD) begin
          if (field_rem == 24'd2) begin
            shift_next = {b, 16'd0};
          end else if (field_rem >= 24'd3) begin
            shift_next = {shift[23:16], shift[7:0], b};
          end
          field_rem_next = field_rem + 1'b1;
          if (field_rem == 24'd4) begin
            if (shift_next[23:16] == tcs_pkg::HOST_NAME_TYPE &&
                {1'b0, shift_next[15:0]} < 17'(SNI_CAPACITY) &&
                shift_next[15:0] <= ext_dec) begin
              host_len_next = shift_next[7:0];
              if (shift_next[15:0] == '0) begin
                phase_next = tcs_pkg::PH_EXT_SKIP;
              end else begin
                phase_next     = tcs_pkg::PH_SNI_NAME;
                field_rem_next = '0;
                shift_next     = {8'd0, shift_next[15:0]};
              end
            end else begin
              phase_next = tcs_pkg::PH_EXT_SKIP;
            end
          end
        end else if (phase == tcs_pkg::PH_SNI_NAME) begin
          out_word.sni_byte_valid = 1'b1;
          out_word.sni_byte       = b;
          out_word.sni_position   = field_rem[7:0];
          field_rem_next          = field_rem + 1'b1;
          if (field_rem_next >= shift) phase_next = tcs_pkg::PH_EXT_SKIP;
        end else if (phase == tcs_pkg::PH_SV) begin
          if (field_rem == '0) begin
            shift_next = {8'd0, b, 8'd0};
          end else if (field_rem[0]) begin
            shift_next = {8'd0, shift[15:8], b};
          end else if (field_rem <= {16'd0, shift[15:8]}) begin
            v = {shift[7:0], b};
            if (v > best) best_next = v;
          end
          field_rem_next = field_rem + 1'b1;
        end
        // extension done: move to next header or stop
        if (ext_dec == '0) begin
          if (exts_dec < 16'd4) begin
            phase_next = tcs_pkg::PH_IDLE;
          end else begin
            phase_next     = tcs_pkg::PH_EXT_TYPE;
            field_rem_next = 24'd2;
            shift_next     = '0;
          end
        end
      end
      default: begin
      end
    endcase

    byte_count_next = (byte_count < tcs_pkg::COUNT_MAX) ? byte_count + 1'b1 : byte_count;
    cnt_inc = byte_count_next;
    rec_end = 18'd5 + {2'd0, hdr_next[15:0]};
    acc     = rec_end <= {1'b0, cnt_inc};
    if (eop) begin
      out_word.summary_valid = 1'b1;
      if (cnt_inc >= 17'd5) begin
        out_word.accepted      = acc;
        out_word.content_type  = hdr_next[39:32];
        out_word.major_version = hdr_next[31:24];
        out_word.minor_version = hdr_next[23:16];
        out_word.record_length = hdr_next[15:0];
        if (acc) begin
          out_word.client_hello = hello_next;
          out_word.max_version  = best_next;
          out_word.sni_length   = host_len_next;
        end
      end
    end
  end

  // update state; end of packet returns to reset
  always_ff @(posedge clk) begin
    if (rst || (step && eop)) begin
      phase      <= tcs_pkg::PH_HDR;
      byte_count <= '0;
      field_rem  <= '0;
      body_rem   <= '0;
      exts_rem   <= '0;
      ext_rem    <= '0;
      shift      <= '0;
      hdr        <= '0;
      best       <= '0;
      host_len   <= '0;
      hello      <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      field_rem  <= field_rem_next;
      body_rem   <= body_rem_next;
      exts_rem   <= exts_rem_next;
      ext_rem    <= ext_rem_next;
      shift      <= shift_next;
      hdr        <= hdr_next;
      best       <= best_next;
      host_len   <= host_len_next;
      hello      <= hello_next;
    end
  end
endmodule

// ===== design/tls_client_hello_sni_parser.sv =====
// A byte goes via the input queue, the parser and the result queue to the result ports.
// Throughput: one byte per cycle unless stalled; the state machine steps once per byte.
// A two-word input queue and a two-word result queue let each side stall alone.
// Reset: rst is synchronous, active high; it empties both queues and returns
// the parser to the record header phase.
module tls_client_hello_sni_parser #(
  parameter int SNI_CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  tcs_pkg::in_word_t  in_data,
  output logic               empty,
  input  logic               pop,
  output tcs_pkg::out_word_t out_data
);
  tcs_pkg::in_word_t  q_word;
  tcs_pkg::out_word_t res_word;
  logic q_empty;
  logic res_full;
  logic step;

  assign step = !q_empty && !res_full;

  // front: hold incoming bytes
  tcs_fifo #(.WIDTH($bits(tcs_pkg::in_word_t)), .DEPTH(2)) u_in_q (
    .clk(clk), .rst(rst),
    .wr_en(push), .wr_data(in_data), .full(full),
    .rd_en(step), .rd_data(q_word), .empty(q_empty)
  );

  // back: parse one byte per step
  tcs_parser #(.SNI_CAPACITY(SNI_CAPACITY)) u_parser (
    .clk(clk), .rst(rst), .step(step),
    .in_word(q_word), .out_word(res_word)
  );

  // results wait here for pop
  tcs_fifo #(.WIDTH($bits(tcs_pkg::out_word_t)), .DEPTH(2)) u_out_q (
    .clk(clk), .rst(rst),
    .wr_en(step), .wr_data(res_word), .full(res_full),
    .rd_en(pop), .rd_data(out_data), .empty(empty)
  );
endmodule
